// ===== rtl/smm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and arithmetic helpers for the square matrix multiply.
// No dependencies; every other file of the block imports this package.
package smm_pkg;

  // Built matrix dimension and element width
  localparam int DIM       = 16;
  localparam int ELEM_BITS = 16;

  // Fixed field widths of the ports
  localparam int FUNC_BITS  = 2;
  localparam int POS_BITS   = 4;
  localparam int VALUE_BITS = 16;
  localparam int SIZE_BITS  = 5;
  localparam int RES_BITS   = 38;

  // Derived widths
  localparam int IDX_BITS   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CNT_BITS   = $clog2(DIM + 1);
  localparam int CMP_BITS   = (CNT_BITS > SIZE_BITS) ? CNT_BITS : SIZE_BITS;
  localparam int ADDR_BITS  = (DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int DEPTH      = DIM * DIM;
  localparam int PROD_BITS  = 2 * ELEM_BITS;
  localparam int WIDE_BITS  = (PROD_BITS > RES_BITS) ? PROD_BITS : RES_BITS + 1;
  localparam int SIZE_RESET = (DIM > 31) ? 31 : DIM;

  // Request function codes
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // One store write
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [ELEM_BITS-1:0] data;
  } wr_t;

  // Tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last_k;
    logic                last_j;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } tag_t;

  // Flat store address of (row, col)
  function automatic logic [ADDR_BITS-1:0] addr_of(input logic [IDX_BITS-1:0] r,
                                                   input logic [IDX_BITS-1:0] c);
    return ADDR_BITS'(ADDR_BITS'(r) * ADDR_BITS'(DIM) + ADDR_BITS'(c));
  endfunction

  // Clamp a wide signed value to the result range
  function automatic logic signed [RES_BITS-1:0] sat_res(
      input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = {{(WIDE_BITS-RES_BITS+1){1'b0}}, {(RES_BITS-1){1'b1}}};
    lo = {{(WIDE_BITS-RES_BITS+1){1'b1}}, {(RES_BITS-1){1'b0}}};
    if (v > hi) begin
      return hi[RES_BITS-1:0];
    end else if (v < lo) begin
      return lo[RES_BITS-1:0];
    end
    return v[RES_BITS-1:0];
  endfunction

endpackage

// ===== rtl/smm_ram.sv =====
`timescale 1ns / 1ps
// Element store: one write port, one read port with registered read data.
// Depends on smm_pkg for depth and widths.
module smm_ram
  import smm_pkg::*;
(
  input  logic                 clk_i,
  input  wr_t                  wr_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [ELEM_BITS-1:0] rdata_o
);

  logic [ELEM_BITS-1:0] mem_q [DEPTH];
  logic [ELEM_BITS-1:0] rdata_q;

  // Write the requested entry
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read; hold the data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smm_ctrl.sv =====
`timescale 1ns / 1ps
// Request decoder and read sequencer: size register, store writes and the
// column/term counters that issue store reads. Depends on smm_pkg.
module smm_ctrl
  import smm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FUNC_BITS-1:0]  func_i,
  input  logic [POS_BITS-1:0]   row_i,
  input  logic [POS_BITS-1:0]   col_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  cfg_we_i,
  input  logic [SIZE_BITS-1:0]  cfg_wdata_i,
  input  logic                  adv_i,
  output wr_t                   wr_a_o,
  output wr_t                   wr_b_o,
  output logic                  re_o,
  output logic [ADDR_BITS-1:0]  raddr_a_o,
  output logic [ADDR_BITS-1:0]  raddr_b_o,
  output tag_t                  tag_o
);

  state_e               state_q, state_d;
  logic [SIZE_BITS-1:0] size_q;
  logic [IDX_BITS-1:0]  row_q, row_d;
  logic [IDX_BITS-1:0]  j_q, j_d;
  logic [IDX_BITS-1:0]  k_q, k_d;
  logic [CMP_BITS-1:0]  n_w;
  logic                 accept_w;
  logic                 in_range_w;
  logic                 start_w;
  logic                 last_k_w;
  logic                 last_j_w;
  logic                 issue_w;
  logic [ELEM_BITS-1:0] elem_w;
  logic [ADDR_BITS-1:0] load_addr_w;

  // Size in use, clamped to the built dimension
  always_comb begin
    if (CMP_BITS'(size_q) > CMP_BITS'(DIM)) begin
      n_w = CMP_BITS'(DIM);
    end else begin
      n_w = CMP_BITS'(size_q);
    end
  end

  assign accept_w   = in_valid_i && !in_stall_o;
  assign in_range_w = (CMP_BITS'(row_i) < CMP_BITS'(DIM)) &&
                      (CMP_BITS'(col_i) < CMP_BITS'(DIM));
  assign start_w    = accept_w && (func_i == FUNC_COMPUTE) &&
                      (CMP_BITS'(row_i) < n_w);
  assign last_k_w   = (CMP_BITS'(k_q) == n_w - CMP_BITS'(1));
  assign last_j_w   = (CMP_BITS'(j_q) == n_w - CMP_BITS'(1));
  assign elem_w     = ELEM_BITS'($signed(value_i));
  assign load_addr_w = addr_of(IDX_BITS'(row_i), IDX_BITS'(col_i));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_w) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv_i && last_k_w && last_j_w) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and counter updates
  always_comb begin
    in_stall_o = 1'b0;
    issue_w    = 1'b0;
    row_d      = row_q;
    j_d        = j_q;
    k_d        = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_w) begin
          row_d = IDX_BITS'(row_i);
          j_d   = '0;
          k_d   = '0;
        end
      end
      ST_RUN: begin
        in_stall_o = 1'b1;
        issue_w    = adv_i;
        if (adv_i) begin
          if (last_k_w) begin
            k_d = '0;
            j_d = j_q + IDX_BITS'(1);
          end else begin
            k_d = k_q + IDX_BITS'(1);
          end
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Store writes for load requests
  always_comb begin
    wr_a_o.we   = accept_w && in_range_w && (func_i == FUNC_LOAD_A);
    wr_a_o.addr = load_addr_w;
    wr_a_o.data = elem_w;
    wr_b_o.we   = accept_w && in_range_w && (func_i == FUNC_LOAD_B);
    wr_b_o.addr = load_addr_w;
    wr_b_o.data = elem_w;
  end

  // Read issue: A row term k, B column j term k
  assign re_o          = issue_w;
  assign raddr_a_o     = addr_of(row_q, k_q);
  assign raddr_b_o     = addr_of(k_q, j_q);
  assign tag_o.valid   = issue_w;
  assign tag_o.first   = (k_q == '0);
  assign tag_o.last_k  = last_k_w;
  assign tag_o.last_j  = last_j_w;
  assign tag_o.row     = row_q;
  assign tag_o.col     = j_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_BITS'(SIZE_RESET);
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // Requested row
  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

endmodule

// ===== rtl/smm_mac.sv =====
`timescale 1ns / 1ps
// Multiply-accumulate pipeline and output register: product stage,
// saturating accumulate, result hold under stall. Depends on smm_pkg.
module smm_mac
  import smm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  tag_t                       tag_i,
  input  logic [ELEM_BITS-1:0]       a_i,
  input  logic [ELEM_BITS-1:0]       b_i,
  output logic                       out_valid_o,
  output logic [POS_BITS-1:0]        result_row_o,
  output logic [POS_BITS-1:0]        result_col_o,
  output logic signed [RES_BITS-1:0] result_value_o,
  output logic                       last_o
);

  tag_t                        t1_q, t2_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [RES_BITS-1:0]  acc_q, acc_d;
  logic signed [RES_BITS-1:0]  prod_sat_w;
  logic                        out_valid_q;
  logic [POS_BITS-1:0]         row_q;
  logic [POS_BITS-1:0]         col_q;
  logic signed [RES_BITS-1:0]  value_q;
  logic                        last_q;

  // Saturating accumulate of the registered product
  always_comb begin
    prod_sat_w = sat_res(WIDE_BITS'(prod_q));
    if (t2_q.first) begin
      acc_d = prod_sat_w;
    end else begin
      acc_d = sat_res(WIDE_BITS'(acc_q) + WIDE_BITS'(prod_sat_w));
    end
  end

  // Advance tags and the output valid; freeze while the result is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q        <= '0;
      t2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      t1_q        <= tag_i;
      t2_q        <= t1_q;
      out_valid_q <= t2_q.valid && t2_q.last_k;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= $signed(a_i) * $signed(b_i);
      if (t2_q.valid) begin
        acc_q <= acc_d;
      end
      if (t2_q.valid && t2_q.last_k) begin
        row_q   <= POS_BITS'(t2_q.row);
        col_q   <= POS_BITS'(t2_q.col);
        value_q <= acc_d;
        last_q  <= t2_q.last_j;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_row_o   = row_q;
  assign result_col_o   = col_q;
  assign result_value_o = value_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/square_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Square matrix multiply top level: A and B stores, read sequencer and
// multiply-accumulate pipeline. Depends on smm_pkg, smm_ram, smm_ctrl, smm_mac.
//
// Usage: requests arrive on the in_* channel (valid/stall). Load A and load B
// requests write one element each. A compute request for row r (r below the
// size in use) streams the n elements of row r of C on the out_* channel in
// column order, last_o marking the final one; other rows and the unused
// function code give nothing. cfg_we_i writes the size register.
// Throughput: a compute request holds the input stalled until its last store
// read issues, one multiply-accumulate per cycle while no result is stalled,
// bounded by the single read port of each store; loads wait then as well.
// After its last read an element passes the read, product and output registers.
// Reset clears the control state and sets the size to the built dimension;
// the stores are not cleared and must be written before they are read.
// When the receiver stalls a waiting result, the whole read and
// multiply-accumulate pipeline freezes until the result is taken; a request
// already sitting in the pipeline is never lost.
module square_matrix_multiply
  import smm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [FUNC_BITS-1:0]        func_i,
  input  logic [POS_BITS-1:0]         row_i,
  input  logic [POS_BITS-1:0]         col_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic                        cfg_we_i,
  input  logic [SIZE_BITS-1:0]        cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [POS_BITS-1:0]         result_row_o,
  output logic [POS_BITS-1:0]         result_col_o,
  output logic signed [RES_BITS-1:0]  result_value_o,
  output logic                        last_o
);

  logic                 adv_w;
  wr_t                  wr_a_w, wr_b_w;
  logic                 re_w;
  logic [ADDR_BITS-1:0] raddr_a_w, raddr_b_w;
  logic [ELEM_BITS-1:0] rdata_a_w, rdata_b_w;
  tag_t                 tag_w;

  // Hold the pipeline while a finished result is stalled
  assign adv_w = !(out_valid_o && out_stall_i);

  smm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv_w),
    .wr_a_o      (wr_a_w),
    .wr_b_o      (wr_b_w),
    .re_o        (re_w),
    .raddr_a_o   (raddr_a_w),
    .raddr_b_o   (raddr_b_w),
    .tag_o       (tag_w)
  );

  smm_ram u_ram_a (
    .clk_i   (clk_i),
    .wr_i    (wr_a_w),
    .re_i    (re_w),
    .raddr_i (raddr_a_w),
    .rdata_o (rdata_a_w)
  );

  smm_ram u_ram_b (
    .clk_i   (clk_i),
    .wr_i    (wr_b_w),
    .re_i    (re_w),
    .raddr_i (raddr_b_w),
    .rdata_o (rdata_b_w)
  );

  smm_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv_w),
    .tag_i          (tag_w),
    .a_i            (rdata_a_w),
    .b_i            (rdata_b_w),
    .out_valid_o    (out_valid_o),
    .result_row_o   (result_row_o),
    .result_col_o   (result_col_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule

// ===== test/tb_square_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Self-checking bench for square_matrix_multiply: loads A and B elements, asks
// for rows of C and checks every element against an in-bench predictor.
// Depends on smm_pkg and the square_matrix_multiply RTL only.
module tb_square_matrix_multiply;
  import smm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = DIM * DIM + 16;
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam longint RES_HI = (longint'(1) <<< (RES_BITS - 1)) - 1;
  localparam longint RES_LO = -RES_HI - 1;

  // Receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HALF  = 2;
  localparam int STALL_HEAVY = 3;

  typedef struct {
    logic [FUNC_BITS-1:0]         func;
    logic [POS_BITS-1:0]          row;
    logic [POS_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] value;
  } request_t;

  typedef struct {
    logic [POS_BITS-1:0]        row;
    logic [POS_BITS-1:0]        col;
    logic signed [RES_BITS-1:0] value;
    logic                       last;
  } c_elem_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [FUNC_BITS-1:0]         func_i;
  logic [POS_BITS-1:0]          row_i;
  logic [POS_BITS-1:0]          col_i;
  logic signed [VALUE_BITS-1:0] value_i;
  logic                         cfg_we_i;
  logic [SIZE_BITS-1:0]         cfg_wdata_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [POS_BITS-1:0]          result_row_o;
  logic [POS_BITS-1:0]          result_col_o;
  logic signed [RES_BITS-1:0]   result_value_o;
  logic                         last_o;

  // Predictor state: mirror of both stores and the size register
  logic signed [ELEM_BITS-1:0] a_mem [DIM][DIM];
  logic signed [ELEM_BITS-1:0] b_mem [DIM][DIM];
  logic [SIZE_BITS-1:0]        size_reg;

  // Stimulus bookkeeping: which entries have been written so far
  bit a_set [DIM][DIM];
  bit b_set [DIM][DIM];

  request_t pending_reqs[$];
  c_elem_t  c_elems_due[$];
  request_t nxt;
  request_t taken;
  c_elem_t  due;

  logic req_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = STALL_NONE;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   queued_count = 0;
  int   loads_seen = 0;
  int   rows_seen = 0;
  int   elems_checked = 0;

  square_matrix_multiply i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_row_o  (result_row_o),
    .result_col_o  (result_col_o),
    .result_value_o(result_value_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Clamp to the signed 38-bit result range
  function automatic longint clamp_res(input longint v);
    if (v > RES_HI) return RES_HI;
    if (v < RES_LO) return RES_LO;
    return v;
  endfunction

  // Update the mirrored stores, or queue the C row that a compute produces
  task automatic predict_request(input request_t q);
    int      n;
    longint  acc;
    c_elem_t e;
    n = (size_reg > DIM) ? DIM : int'(size_reg);
    if (q.func == FUNC_LOAD_A) begin
      a_mem[q.row][q.col] = q.value;
      loads_seen++;
    end else if (q.func == FUNC_LOAD_B) begin
      b_mem[q.row][q.col] = q.value;
      loads_seen++;
    end else if (q.func == FUNC_COMPUTE && int'(q.row) < n) begin
      rows_seen++;
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          acc = clamp_res(acc + clamp_res(longint'(a_mem[q.row][k]) *
                                          longint'(b_mem[k][j])));
        end
        e.row   = q.row;
        e.col   = j[POS_BITS-1:0];
        e.value = acc[RES_BITS-1:0];
        e.last  = (j == n - 1);
        c_elems_due.push_back(e);
      end
    end
  endtask

  // Value with extra weight on the extremes
  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_req(input logic [FUNC_BITS-1:0] f, input int r, input int c,
                           input logic signed [VALUE_BITS-1:0] v);
    request_t q;
    q.func  = f;
    q.row   = r[POS_BITS-1:0];
    q.col   = c[POS_BITS-1:0];
    q.value = v;
    if (f == FUNC_LOAD_A) a_set[q.row][q.col] = 1'b1;
    if (f == FUNC_LOAD_B) b_set[q.row][q.col] = 1'b1;
    pending_reqs.push_back(q);
    queued_count++;
  endtask

  // Load whatever row r of C still needs, in shuffled order, then ask for it
  task automatic queue_row_job(input int n, input int r);
    int cells[$];
    int tmp;
    int idx;
    for (int k = 0; k < n; k++) begin
      if (!a_set[r][k]) cells.push_back((r << 4) | k);
      for (int j = 0; j < n; j++) begin
        if (!b_set[k][j]) cells.push_back(256 | (k << 4) | j);
      end
    end
    // Overwrite a few entries already in use
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1)) cells.push_back((r << 4) | $urandom_range(0, n - 1));
      else cells.push_back(256 | ($urandom_range(0, n - 1) << 4) | $urandom_range(0, n - 1));
    end
    for (int i = cells.size() - 1; i > 0; i--) begin
      idx = $urandom_range(0, i);
      tmp = cells[i];
      cells[i] = cells[idx];
      cells[idx] = tmp;
    end
    foreach (cells[i]) begin
      queue_req(cells[i][8] ? FUNC_LOAD_B : FUNC_LOAD_A, int'(cells[i][7:4]),
                int'(cells[i][3:0]), rand_value());
    end
    queue_req(FUNC_COMPUTE, r, $urandom, rand_value());
  endtask

  // Requests that give no result: unused code, row beyond size, stray loads
  task automatic queue_noise(input int n);
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 1 && n < DIM) begin
      queue_req(FUNC_COMPUTE, $urandom_range(n, DIM - 1), $urandom, rand_value());
    end else if (pick == 2) begin
      queue_req($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A, $urandom, $urandom,
                rand_value());
    end else begin
      queue_req(FUNC_UNUSED, $urandom, $urandom, VALUE_BITS'($urandom));
    end
  endtask

  // Row jobs at the full dimension would need every B entry; keep those to noise
  task automatic queue_random(input int n, input int quota);
    int stop_at;
    stop_at = queued_count + quota;
    while (queued_count < stop_at) begin
      if (n > 0 && n < DIM && $urandom_range(0, 3) != 0) begin
        queue_row_job(n, $urandom_range(0, n - 1));
      end else begin
        queue_noise(n);
      end
    end
  endtask

  // Hold off until every request is taken and every C element has come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || c_elems_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input int s);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s[SIZE_BITS-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    int sizes[8];
    int quotas[8];
    sizes  = '{0, 1, 3, 16, 5, 31, 2, 6};
    quotas = '{6, 10, 14, 6, 20, 6, 10, 24};
    in_valid_i  = 1'b0;
    func_i      = FUNC_LOAD_A;
    row_i       = '0;
    col_i       = '0;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    out_stall_i = 1'b0;
    size_reg    = SIZE_BITS'(DIM);
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size: loads at the field extremes and the unused code
    queue_req(FUNC_LOAD_A, 0, 0, 16'sh8000);
    queue_req(FUNC_LOAD_A, 0, 1, 16'sh8000);
    queue_req(FUNC_LOAD_B, 0, 0, 16'sh8000);
    queue_req(FUNC_LOAD_B, 1, 0, 16'sh8000);
    queue_req(FUNC_LOAD_A, 15, 15, 16'sh7fff);
    queue_req(FUNC_LOAD_B, 15, 15, -16'sd1);
    queue_req(FUNC_UNUSED, 15, 15, 16'sh8000);
    wait_drained();

    // Size 2: full rows, rows beyond size, overwrite, ignored compute fields
    write_size(2);
    queue_req(FUNC_LOAD_B, 0, 1, 16'sh7fff);
    queue_req(FUNC_LOAD_B, 1, 1, 16'sh8000);
    queue_req(FUNC_COMPUTE, 0, 15, -16'sd1);
    queue_req(FUNC_LOAD_A, 1, 0, 16'sh7fff);
    queue_req(FUNC_LOAD_A, 1, 1, 16'sh0000);
    queue_req(FUNC_COMPUTE, 1, 0, 16'sh0000);
    queue_req(FUNC_COMPUTE, 2, 0, 16'sh0000);
    queue_req(FUNC_COMPUTE, 15, 15, 16'sh7fff);
    queue_req(FUNC_LOAD_A, 0, 1, 16'sh7fff);
    queue_req(FUNC_COMPUTE, 0, 0, 16'sh0000);
    queue_req(FUNC_UNUSED, 0, 0, 16'sh0000);
    wait_drained();

    // Random phases over several sizes, zero and above the built size included
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      queue_random((sizes[i] > DIM) ? DIM : sizes[i], quotas[i]);
      wait_drained();
    end

    $display("Run covered %0d loads and %0d row computes at sizes 0 to 31;",
             loads_seen, rows_seen);
    $display("%0d C elements were compared field by field.", elems_checked);
    if (error_count == 0) begin
      $display("tb_square_matrix_multiply: PASS");
    end else begin
      $display("tb_square_matrix_multiply: FAIL");
    end
    $finish;
  end

  // Request driver: bursts with random gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (!(in_valid_i && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        nxt = pending_reqs.pop_front();
        func_i     <= nxt.func;
        row_i      <= nxt.row;
        col_i      <= nxt.col;
        value_i    <= nxt.value;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall pattern: hold a randomly chosen mode for a random span, then pick anew
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 1);
      default:     out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: track size writes and taken requests, check each C element
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) size_reg = cfg_wdata_i;
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        taken.func  = func_i;
        taken.row   = row_i;
        taken.col   = col_i;
        taken.value = value_i;
        predict_request(taken);
      end
      if (out_valid_o && !out_stall_i) begin
        if (c_elems_due.size() == 0) begin
          $error("C element with nothing due: row %0d col %0d value %0d",
                 result_row_o, result_col_o, result_value_o);
          error_count++;
        end else begin
          due = c_elems_due.pop_front();
          elems_checked++;
          if (result_row_o !== due.row) begin
            $error("result_row: expected %0d, actual %0d", due.row, result_row_o);
            error_count++;
          end
          if (result_col_o !== due.col) begin
            $error("result_col: expected %0d, actual %0d", due.col, result_col_o);
            error_count++;
          end
          if (result_value_o !== due.value) begin
            $error("result_value: expected %0d, actual %0d", due.value, result_value_o);
            error_count++;
          end
          if (last_o !== due.last) begin
            $error("last: expected %0d, actual %0d", due.last, last_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d C elements still due", cycle_count,
             c_elems_due.size());
      $display("tb_square_matrix_multiply: FAIL");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_ctrl.sv
rtl/smm_mac.sv
rtl/square_matrix_multiply.sv
test/tb_square_matrix_multiply.sv
